/* sv/cst_pkg.sv */
// Package with shared types and codes for the counting semaphore table.
`timescale 1ns / 1ps
package cst_pkg;

  typedef enum logic [1:0] {
    ACT_OPEN  = 2'd0,
    ACT_WAIT  = 2'd1,
    ACT_POST  = 2'd2,
    ACT_CLOSE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_FREED = 2'd2
  } status_e;

  localparam int unsigned KeyW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned PidW = 16;
  localparam int unsigned ListenW = 8;
  localparam int unsigned SlotOutW = 4;

  typedef struct packed {
    logic [1:0]     action;
    logic [31:0]    sem_id;
    logic [15:0]    init_value;
    logic [15:0]    caller_pid;
  } req_t;

  typedef struct packed {
    logic [1:0]     status;
    logic [3:0]     slot_index;
    logic           caller_blocked;
    logic           wake_valid;
    logic [15:0]    wake_pid;
    logic           last_result;
  } rsp_t;

endpackage

/* sv/cst_if.sv */
// Valid-ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface cst_req_if import cst_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cst_rsp_if import cst_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/counting_semaphore_table.sv */
// Top level of the counting semaphore table; one request is in flight at a time.
// After accept the slots are scanned one per cycle, the target slot is read, the action runs
// and the first result beat goes out. A last close with n queued waiters sends its n wake
// beats and the final beat one per cycle while the sink does not stall. The next request is
// accepted with the last beat. Reset clears the slot valid bits at once; invalid entries read
// as all zeros.
`timescale 1ns / 1ps
module counting_semaphore_table import cst_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cst_req_if.sink   req,
  cst_rsp_if.source rsp
);
  localparam int unsigned SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned QPtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned TotW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QMemDepth = SLOT_COUNT * (2 ** QPtrW);
  localparam logic [SlotW:0] LastSlot = (SlotW + 1)'(SLOT_COUNT - 1);
  localparam logic [TotW-1:0] QFull = TotW'(QUEUE_DEPTH);
  localparam logic [QPtrW-1:0] QLast = QPtrW'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [CountW-1:0]  count;
    logic [ListenW-1:0] listeners;
    logic [TotW-1:0]    total;
    logic [QPtrW-1:0]   head;
  } slot_t;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [SLOT_COUNT-1:0] used_q;
  slot_t smem [SLOT_COUNT];
  slot_t srd_q;
  logic [SlotW-1:0] sraddr;
  logic             swe;
  logic [SlotW-1:0] swaddr;
  slot_t            swdata;

  req_t req_q;
  logic [SlotW:0] scan_q;
  logic [SlotW-1:0] rd_slot_q;
  logic found_q, free_ok_q;
  logic [SlotW-1:0] hit_q, free_q;
  logic [TotW-1:0] drain_q;
  logic [QPtrW-1:0] dptr_q;
  logic drain_first_q;
  rsp_t rsp_q;
  logic rsp_valid_q;

  logic qwe;
  logic [SlotW+QPtrW-1:0] qwaddr, qraddr;
  logic [PidW-1:0] qrdata;

  // Slot state memory.
  always_ff @(posedge clk_i) begin
    if (swe) begin
      smem[swaddr] <= swdata;
    end
    srd_q <= smem[sraddr];
  end

  cst_queue_mem #(.SlotW(SlotW), .QPtrW(QPtrW), .Depth(QMemDepth)) u_qmem (
    .clk_i   (clk_i),
    .we_i    (qwe),
    .waddr_i (qwaddr),
    .wdata_i (req_q.caller_pid),
    .raddr_i (qraddr),
    .rdata_o (qrdata)
  );

  logic [SlotW-1:0] cur_slot;
  logic             rd_used_q;
  slot_t cur;
  logic [QPtrW:0]   tail_sum;
  logic [QPtrW-1:0] tail_ptr, next_head, next_dptr;
  logic [SlotW-1:0] tgt;

  assign cur = rd_used_q ? srd_q : '0;
  assign tgt = found_q ? hit_q : free_q;
  assign tail_sum = {1'b0, cur.head} + {1'b0, QPtrW'(cur.total)};
  assign tail_ptr = (tail_sum > {1'b0, QLast}) ?
                    QPtrW'(tail_sum - (QPtrW + 1)'(QUEUE_DEPTH)) :
                    tail_sum[QPtrW-1:0];
  assign next_head = (cur.head == QLast) ? '0 : cur.head + 1'b1;
  assign next_dptr = (dptr_q == QLast) ? '0 : dptr_q + 1'b1;
  assign cur_slot = scan_q[SlotW-1:0];

  function automatic rsp_t mk(logic [1:0] st, logic [SlotW-1:0] s, logic blk,
                              logic wv, logic [PidW-1:0] p, logic last);
    rsp_t r;
    r.status = st;
    r.slot_index = SlotOutW'({{SlotOutW{1'b0}}, s});
    r.caller_blocked = blk;
    r.wake_valid = wv;
    r.wake_pid = p;
    r.last_result = last;
    return r;
  endfunction

  assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  always_comb begin
    state_d = state_q;
    sraddr = cur_slot;
    swe = 1'b0;
    swaddr = tgt;
    swdata = cur;
    qwe = 1'b0;
    qwaddr = {tgt, tail_ptr};
    qraddr = {tgt, dptr_q};
    unique case (state_q)
      S_IDLE: if (req.valid && req.ready) state_d = S_SCAN;
      S_SCAN: if (scan_q == LastSlot + 1'b1) state_d = S_READ;
      S_READ: begin
        sraddr = tgt;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
        unique case (action_e'(req_q.action))
          ACT_OPEN: begin
            if (found_q || free_ok_q) begin
              swe = 1'b1;
              if (found_q) begin
                if (cur.listeners != '1) swdata.listeners = cur.listeners + 1'b1;
              end else begin
                swdata = '0;
                swdata.key = req_q.sem_id;
                swdata.count = req_q.init_value;
                swdata.listeners = ListenW'(1);
              end
            end
          end
          ACT_WAIT: begin
            if (found_q) begin
              if (cur.count != '0) begin
                swe = 1'b1;
                swdata.count = cur.count - 1'b1;
              end else if (cur.total < QFull) begin
                swe = 1'b1;
                qwe = 1'b1;
                swdata.total = cur.total + 1'b1;
              end
            end
          end
          ACT_POST: begin
            if (found_q) begin
              swe = 1'b1;
              if (cur.total != '0) begin
                qraddr = {tgt, cur.head};
                swdata.total = cur.total - 1'b1;
                swdata.head = next_head;
              end else if (cur.count != '1) begin
                swdata.count = cur.count + 1'b1;
              end
            end
          end
          ACT_CLOSE: begin
            if (found_q) begin
              swe = 1'b1;
              if (cur.listeners > ListenW'(1)) begin
                swdata.listeners = cur.listeners - 1'b1;
              end else begin
                swdata = '0;
                qraddr = {tgt, cur.head};
                if (cur.total != '0) state_d = S_DRAIN;
              end
            end
          end
          default: ;
        endcase
      end
      S_DRAIN: begin
        qraddr = {tgt, next_dptr};
        if (!rsp_valid_q || rsp.ready) begin
          if (drain_q == TotW'(1)) state_d = S_OUT;
        end else begin
          qraddr = {tgt, dptr_q};
        end
      end
      S_OUT: if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic drain_fire;
  assign drain_fire = (state_q == S_DRAIN) && (!rsp_valid_q || rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (drain_fire || (state_q == S_OUT && (!rsp_valid_q || rsp.ready))) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (state_q == S_EXEC && swe) begin
        if (req_q.action == ACT_OPEN) used_q[tgt] <= 1'b1;
        else if (req_q.action == ACT_CLOSE && cur.listeners <= ListenW'(1))
          used_q[tgt] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_used_q <= used_q[sraddr];
    rd_slot_q <= cur_slot;
    unique case (state_q)
      S_IDLE: begin
        req_q <= req.payload;
        scan_q <= '0;
        found_q <= 1'b0;
        free_ok_q <= 1'b0;
        hit_q <= '0;
        free_q <= '0;
      end
      S_SCAN: begin
        scan_q <= scan_q + 1'b1;
        if (scan_q != '0 && !found_q && rd_used_q && srd_q.key == req_q.sem_id) begin
          found_q <= 1'b1;
          hit_q <= rd_slot_q;
        end
        if (scan_q != '0 && !free_ok_q && !rd_used_q) begin
          free_ok_q <= 1'b1;
          free_q <= rd_slot_q;
        end
      end
      S_EXEC: begin
        drain_q <= cur.total;
        dptr_q <= cur.head;
        drain_first_q <= 1'b1;
        unique case (action_e'(req_q.action))
          ACT_OPEN: rsp_q <= (found_q || free_ok_q) ? mk(ST_OK, tgt, 1'b0, 1'b0, '0, 1'b1)
                                                    : mk(ST_ERROR, '0, 1'b0, 1'b0, '0, 1'b1);
          ACT_WAIT: begin
            if (!found_q) rsp_q <= mk(ST_ERROR, '0, 1'b0, 1'b0, '0, 1'b1);
            else if (cur.count != '0) rsp_q <= mk(ST_OK, tgt, 1'b0, 1'b0, '0, 1'b1);
            else if (cur.total >= QFull) rsp_q <= mk(ST_ERROR, tgt, 1'b0, 1'b0, '0, 1'b1);
            else rsp_q <= mk(ST_OK, tgt, 1'b1, 1'b0, '0, 1'b1);
          end
          ACT_POST: begin
            if (!found_q) rsp_q <= mk(ST_ERROR, '0, 1'b0, 1'b0, '0, 1'b1);
            else if (cur.total != '0) rsp_q <= mk(ST_OK, tgt, 1'b0, 1'b1, '0, 1'b1);
            else rsp_q <= mk(ST_OK, tgt, 1'b0, 1'b0, '0, 1'b1);
          end
          ACT_CLOSE: begin
            if (!found_q) rsp_q <= mk(ST_ERROR, '0, 1'b0, 1'b0, '0, 1'b1);
            else if (cur.listeners > ListenW'(1))
              rsp_q <= mk(ST_OK, tgt, 1'b0, 1'b0, '0, 1'b1);
            else rsp_q <= mk(ST_FREED, tgt, 1'b0, 1'b0, '0, 1'b1);
          end
          default: ;
        endcase
      end
      S_DRAIN: begin
        if (drain_fire) begin
          rsp_q <= mk(ST_FREED, tgt, 1'b0, 1'b1, qrdata, 1'b0);
          drain_q <= drain_q - 1'b1;
          dptr_q <= next_dptr;
          drain_first_q <= 1'b0;
        end
      end
      S_OUT: begin
        if (drain_first_q && req_q.action == ACT_POST && rsp_q.wake_valid)
          rsp_q.wake_pid <= qrdata;
        drain_first_q <= 1'b0;
        if (!drain_first_q && (!rsp_valid_q || rsp.ready))
          rsp_q <= mk(ST_FREED, tgt, 1'b0, 1'b0, '0, 1'b1);
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("Request accepted while busy.");
  a_drain_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.payload.wake_valid && rsp.payload.status == ST_FREED)
      |-> !rsp.payload.last_result)
    else $error("Drain beat marked last.");
  a_blocked_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.payload.caller_blocked) |-> rsp.payload.status == ST_OK)
    else $error("Blocked caller with error status.");
`endif
endmodule

/* sv/cst_queue_mem.sv */
// Wait queue memory: one circular FIFO region per slot, registered read.
`timescale 1ns / 1ps
module cst_queue_mem import cst_pkg::*; #(
  parameter int unsigned SlotW = 4,
  parameter int unsigned QPtrW = 4,
  parameter int unsigned Depth = 256
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [SlotW+QPtrW-1:0] waddr_i,
  input  logic [PidW-1:0]        wdata_i,
  input  logic [SlotW+QPtrW-1:0] raddr_i,
  output logic [PidW-1:0]        rdata_o
);
  logic [PidW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
